### rtl/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

    // Request kinds carried in the input tuser field.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_TOP    = 2'd2;

    // Width of the reported entry count.
    localparam int COUNT_W = 5;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_WR,
        S_SCAN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic pop_read;
        logic pop_write;
        logic scan;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic pop_go;
        logic scan_done;
    } t_status;

endpackage

### rtl/mpq_ctrl.sv
`timescale 1ns / 1ps

module mpq_ctrl import mpq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.out_free && i_status.pop_go) begin
                    n_state = S_POP_RD;
                end
            end
            S_POP_RD: begin
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
            end
            S_POP_RD: begin
                o_cmd.pop_read = 1'b1;
            end
            S_POP_WR: begin
                o_cmd.pop_write = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/mpq_dp.sv
`timescale 1ns / 1ps

module mpq_dp import mpq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [1:0]               i_req_type,
    input  logic signed [31:0]       i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [31:0]       o_min_value,
    output logic                     o_is_empty,
    output logic [COUNT_W-1:0]       o_entry_count,
    output logic                     o_req_error
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW = $clog2(CAPACITY + 1);
    localparam logic [OW-1:0] CAP_OCC = OW'(CAPACITY);

    logic [31:0]        r_mem [CAPACITY];
    logic [31:0]        r_rd_data;

    logic [OW-1:0]      r_occ;
    logic [SW-1:0]      r_min_slot;
    logic signed [31:0] r_min_val;
    logic [OW-1:0]      r_scan_addr;
    logic [SW-1:0]      r_cmp_idx;
    logic               r_cmp_valid;

    logic               r_out_valid;
    logic signed [31:0] r_out_min;
    logic               r_out_empty;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_err;

    logic               full;
    logic               empty;
    logic               ins_ok;
    logic               ins_new_min;
    logic               scan_issue;
    logic               scan_take;
    logic               mem_we;
    logic [SW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic               mem_re;
    logic [SW-1:0]      mem_raddr;

    assign full        = (r_occ == CAP_OCC);
    assign empty       = (r_occ == '0);
    assign ins_ok      = i_cmd.accept && (i_req_type == REQ_INSERT) && !full;
    assign ins_new_min = empty || (i_value < r_min_val);
    assign scan_issue  = i_cmd.scan && (r_scan_addr < r_occ);
    assign scan_take   = r_cmp_valid &&
                         ((r_cmp_idx == '0) || ($signed(r_rd_data) <= r_min_val));

    // Status toward the controller.
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.pop_go    = (i_req_type == REQ_POP) && !empty;
    assign o_status.scan_done = (r_scan_addr == r_occ) && !r_cmp_valid;

    // Write port: inserts append, a pop moves the last entry into the hole.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_occ[SW-1:0];
        mem_wdata = i_value;
        if (ins_ok) begin
            mem_we = 1'b1;
        end else if (i_cmd.pop_write) begin
            mem_we    = 1'b1;
            mem_waddr = r_min_slot;
            mem_wdata = r_rd_data;
        end
    end

    // Read port: the last entry for a pop, then every entry during the rescan.
    always_comb begin
        mem_re    = i_cmd.pop_read || scan_issue;
        mem_raddr = r_scan_addr[SW-1:0];
        if (i_cmd.pop_read) begin
            mem_raddr = SW'(r_occ - 1'b1);
        end
    end

    // Entry storage with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Occupancy, tracked minimum and rescan pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_min_slot  <= '0;
            r_scan_addr <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (ins_ok) begin
                r_occ <= r_occ + 1'b1;
                if (ins_new_min) begin
                    r_min_slot <= r_occ[SW-1:0];
                end
            end
            if (i_cmd.pop_write) begin
                r_occ       <= r_occ - 1'b1;
                r_min_slot  <= '0;
                r_scan_addr <= '0;
                r_cmp_valid <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_cmp_valid <= scan_issue;
                if (scan_issue) begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                end
                if (scan_take) begin
                    r_min_slot <= r_cmp_idx;
                end
            end
        end
    end

    // Payload side of the tracked minimum.
    always_ff @(posedge i_clk) begin
        if (ins_ok && ins_new_min) begin
            r_min_val <= i_value;
        end
        if (i_cmd.scan && scan_take) begin
            r_min_val <= $signed(r_rd_data);
        end
        if (scan_issue) begin
            r_cmp_idx <= r_scan_addr[SW-1:0];
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.accept && !o_status.pop_go) || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: immediate requests on acceptance, pops after the rescan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !o_status.pop_go) begin
            r_out_min   <= empty ? 32'sd0 : r_min_val;
            r_out_empty <= empty;
            r_out_count <= COUNT_W'(r_occ);
            unique case (i_req_type) inside
                REQ_INSERT: begin
                    r_out_err <= full;
                    if (!full) begin
                        r_out_min   <= ins_new_min ? i_value : r_min_val;
                        r_out_empty <= 1'b0;
                        r_out_count <= COUNT_W'(r_occ + 1'b1);
                    end
                end
                REQ_POP, REQ_TOP: begin
                    r_out_err <= empty;
                end
                default: begin
                    r_out_err <= 1'b1;
                end
            endcase
        end else if (i_cmd.finish) begin
            r_out_min   <= empty ? 32'sd0 : r_min_val;
            r_out_empty <= empty;
            r_out_count <= COUNT_W'(r_occ);
            r_out_err   <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_value   = r_out_min;
    assign o_is_empty    = r_out_empty;
    assign o_entry_count = r_out_count;
    assign o_req_error   = r_out_err;

endmodule

### rtl/min_priority_queue.sv
`timescale 1ns / 1ps
// Insert, top and error requests answer in the cycle after acceptance; a new request can follow
// each cycle while the result register drains.
// A successful pop refills the hole from the last entry, then rescans all N remaining entries
// through the single registered memory read port.
// Reset (synchronous, active low) empties the queue at once; entry storage is not cleared.
module min_priority_queue import mpq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tuser: [1:0] req_type
    input  logic [1:0]  i_s_axis_tuser,
    // tdata: [31:0] value
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: [31:0] min_value, [32] is_empty, [37:33] entry_count, [38] req_error, [39] zero
    output logic [39:0] o_m_axis_tdata
);

    t_cmd               cmd;
    t_status            status;
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
    logic               req_error;

    // Sequencing of requests and pop rescans.
    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Entry storage, minimum tracking and result register.
    mpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_type    (i_s_axis_tuser),
        .i_value       ($signed(i_s_axis_tdata)),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_min_value   (min_value),
        .o_is_empty    (is_empty),
        .o_entry_count (entry_count),
        .o_req_error   (req_error)
    );

    // Pack the result transaction.
    assign o_m_axis_tdata = {1'b0, req_error, entry_count, is_empty, min_value};

endmodule
